@@ rtl/jkem_pkg.sv @@
// ----------------------------------------------------------------------------
// jkem_pkg
// Shared types and constants for the joystick to key event mapper.
// ----------------------------------------------------------------------------
package jkem_pkg;

    localparam int NKEYS   = 9;
    localparam int KEY_W   = $clog2(NKEYS);
    localparam int CODE_W  = 8;
    localparam int JOY_W   = 8;
    localparam int HOLD_W  = 4;
    localparam int SHOT_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;
    localparam int MOVE_W   = 32;
    localparam int ACTION_W = 40;

    localparam logic [HOLD_W-1:0] HOLD_TICKS = HOLD_W'(8);
    localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
    localparam logic [SHOT_W-1:0] SHOT_LEN   = SHOT_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_CODES   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_CODES = CFG_IDX_W'(1);

    localparam logic [JOY_W-1:0] JOY_IDLE = 8'hff;
    localparam int JOY_UP    = 0;
    localparam int JOY_DOWN  = 1;
    localparam int JOY_LEFT  = 2;
    localparam int JOY_RIGHT = 3;
    localparam int JOY_FIRE  = 4;

    localparam int K_UP     = 0;
    localparam int K_DOWN   = 1;
    localparam int K_SPEED  = 2;
    localparam int K_LEFT   = 3;
    localparam int K_RIGHT  = 4;
    localparam int K_SLEFT  = 5;
    localparam int K_SRIGHT = 6;
    localparam int K_FIRE   = 7;
    localparam int K_USE    = 8;

    // key visited at each slot when releasing everything
    localparam logic [KEY_W-1:0] RELEASE_ORDER [NKEYS] = '{
        KEY_W'(K_UP), KEY_W'(K_DOWN), KEY_W'(K_LEFT), KEY_W'(K_RIGHT),
        KEY_W'(K_SLEFT), KEY_W'(K_SRIGHT), KEY_W'(K_SPEED), KEY_W'(K_FIRE),
        KEY_W'(K_USE)
    };

    localparam int QDEPTH  = 2;
    localparam int QADDR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic                           inactive;
        logic [NKEYS-1:0]               want;
        logic [NKEYS-1:0][CODE_W-1:0]   code;
    } jkem_item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } jkem_qstat_t;

endpackage

@@ rtl/jkem_front.sv @@
// ----------------------------------------------------------------------------
// jkem_front
// Accepts poll ticks, tracks fire hold and shot, forms desired key states.
// ----------------------------------------------------------------------------
module jkem_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jkem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jkem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_active,
    input  logic [jkem_pkg::JOY_W-1:0]       in_joy,
    input  jkem_pkg::jkem_qstat_t            q_stat,
    output logic                             q_push,
    output jkem_pkg::jkem_item_t             q_item
);
    import jkem_pkg::*;

    logic [MOVE_W-1:0]   move_reg;
    logic [ACTION_W-1:0] action_reg;
    logic                fire_before_reg, fire_before_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [SHOT_W-1:0]   shot_reg, shot_next;

    logic [JOY_W-1:0]  joy;
    logic              up, down, left, right, fire, dir, use_wanted;
    logic [HOLD_W-1:0] hold_new;
    logic [SHOT_W-1:0] shot_new;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_stat.full;
    assign q_push    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_reg   <= '0;
            action_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MOVE_CODES)
                move_reg <= cfg_data[MOVE_W-1:0];
            else if (cfg_index == CFG_ACTION_CODES)
                action_reg <= cfg_data[ACTION_W-1:0];
        end
    end

    always_comb
    begin
        joy      = (in_joy == '0) ? JOY_IDLE : in_joy;
        up       = !joy[JOY_UP];
        down     = !joy[JOY_DOWN];
        left     = !joy[JOY_LEFT];
        right    = !joy[JOY_RIGHT];
        fire     = !joy[JOY_FIRE];
        dir      = up || down || left || right;

        if (fire)
        begin
            hold_new = (hold_reg != HOLD_MAX) ? hold_reg + HOLD_W'(1) : hold_reg;
            shot_new = fire_before_reg ? shot_reg : SHOT_LEN;
        end
        else
        begin
            hold_new = '0;
            shot_new = '0;
        end
        use_wanted = fire && !dir && (hold_new >= HOLD_TICKS);

        q_item = '0;
        q_item.inactive = !in_active;
        if (in_active)
        begin
            q_item.want[K_UP]     = up;
            q_item.want[K_DOWN]   = down;
            q_item.want[K_SPEED]  = fire && (up || down);
            q_item.want[K_LEFT]   = left && !fire;
            q_item.want[K_RIGHT]  = right && !fire;
            q_item.want[K_SLEFT]  = left && fire;
            q_item.want[K_SRIGHT] = right && fire;
            q_item.want[K_FIRE]   = (shot_new != '0) && !use_wanted;
            q_item.want[K_USE]    = use_wanted;
            q_item.code[K_UP]     = move_reg[7:0];
            q_item.code[K_DOWN]   = move_reg[15:8];
            q_item.code[K_LEFT]   = move_reg[23:16];
            q_item.code[K_RIGHT]  = move_reg[31:24];
            q_item.code[K_SLEFT]  = action_reg[7:0];
            q_item.code[K_SRIGHT] = action_reg[15:8];
            q_item.code[K_SPEED]  = action_reg[23:16];
            q_item.code[K_FIRE]   = action_reg[31:24];
            q_item.code[K_USE]    = action_reg[39:32];
            hold_next        = hold_new;
            shot_next        = (shot_new != '0) ? shot_new - SHOT_W'(1) : shot_new;
            fire_before_next = fire;
        end
        else
        begin
            hold_next        = '0;
            shot_next        = '0;
            fire_before_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_before_reg <= 1'b0;
            hold_reg        <= '0;
            shot_reg        <= '0;
        end
        else if (q_push)
        begin
            fire_before_reg <= fire_before_next;
            hold_reg        <= hold_next;
            shot_reg        <= shot_next;
        end
    end

endmodule

@@ rtl/jkem_fifo.sv @@
// ----------------------------------------------------------------------------
// jkem_fifo
// Short queue of classified ticks between the front and back parts.
// ----------------------------------------------------------------------------
module jkem_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  jkem_pkg::jkem_item_t   push_item,
    input  logic                   pop,
    output jkem_pkg::jkem_item_t   head_item,
    output jkem_pkg::jkem_qstat_t  stat
);
    import jkem_pkg::*;

    jkem_item_t           mem_reg [QDEPTH];
    logic [QADDR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QADDR_W:0]     count_reg, count_next;

    assign stat.full  = (count_reg == (QADDR_W+1)'(QDEPTH));
    assign stat.valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QADDR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QADDR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QADDR_W'(QDEPTH-1)) ? '0
                                                                  : wr_ptr_reg + QADDR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QADDR_W'(QDEPTH-1)) ? '0
                                                                  : rd_ptr_reg + QADDR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/jkem_back.sv @@
// ----------------------------------------------------------------------------
// jkem_back
// Holds per-key state and serialises release and press events per tick.
// ----------------------------------------------------------------------------
module jkem_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  jkem_pkg::jkem_item_t           q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [jkem_pkg::CODE_W-1:0]    out_code,
    output logic                           out_pressed,
    output logic                           out_last
);
    import jkem_pkg::*;

    logic [NKEYS-1:0]  held_reg;
    logic [CODE_W-1:0] hc_reg [NKEYS];

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_pressed_reg;
    logic              out_last_reg;

    logic [KEY_W-1:0]  key_s [NKEYS];
    logic [NKEYS-1:0]  rel, prs, any_ev;
    logic [2*NKEYS-1:0] ev_all;
    logic [KEY_W-1:0]  sel;
    logic [KEY_W-1:0]  sel_key;
    logic              found, load, ev_last, ev_press;
    logic [CODE_W-1:0] ev_code;

    always_comb
    begin
        for (int s = 0; s < NKEYS; s++)
        begin
            key_s[s] = q_item.inactive ? RELEASE_ORDER[s] : KEY_W'(s);
            rel[s]   = held_reg[key_s[s]] &&
                       (!q_item.want[s] || hc_reg[key_s[s]] != q_item.code[s]);
            prs[s]   = q_item.want[s] && (q_item.code[s] != '0) &&
                       (!held_reg[key_s[s]] || rel[s]);
        end
        any_ev = rel | prs;
        ev_all = {prs, rel};
        found  = q_valid && (any_ev != '0);
        sel    = '0;
        for (int s = NKEYS-1; s >= 0; s--)
        begin
            if (any_ev[s])
                sel = KEY_W'(s);
        end
        sel_key  = key_s[sel];
        ev_press = !rel[sel];
        ev_code  = rel[sel] ? hc_reg[sel_key] : q_item.code[sel];
        ev_last  = (ev_all != '0) && ((ev_all & (ev_all - (2*NKEYS)'(1))) == '0);
        load     = found && (!out_valid_reg || out_ready);
        q_pop    = q_valid && ((any_ev == '0) || (load && ev_last));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            for (int k = 0; k < NKEYS; k++)
                hc_reg[k] <= '0;
        end
        else if (load)
        begin
            held_reg[sel_key] <= ev_press;
            if (ev_press)
                hc_reg[sel_key] <= ev_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_code_reg    <= ev_code;
            out_pressed_reg <= ev_press;
            out_last_reg    <= ev_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_code    = out_code_reg;
    assign out_pressed = out_pressed_reg;
    assign out_last    = out_last_reg;

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_code_reg != '0)
        else $error("event with zero key code");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && any_ev == '0) |-> q_pop)
        else $error("tick without events not retired");

    a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (load && ev_last) |-> q_pop)
        else $error("final event did not retire tick");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !ev_press) |=> !held_reg[$past(sel_key)])
        else $error("key still held after release");

endmodule

@@ rtl/joystick_to_key_event_mapper.sv @@
// ----------------------------------------------------------------------------
// joystick_to_key_event_mapper
// Turns polled joystick ticks into a stream of virtual key release/press
// transactions.
// Path: a tick is queued, then its first event is registered at the output.
// Throughput: one event per cycle from the back part while m_axis_tready is
// high; a tick yields up to 18 events; a two-entry queue decouples the parts.
// Reset: key state, fire tracking, key codes and queue all cleared at once.
// ----------------------------------------------------------------------------
module joystick_to_key_event_mapper (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jkem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jkem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] joy_byte
    input  logic                             s_axis_tuser,   // [0] active
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] key_code
    output logic                             m_axis_tuser,   // [0] pressed
    output logic                             m_axis_tlast
);
    import jkem_pkg::*;

    jkem_item_t  push_item, head_item;
    jkem_qstat_t q_stat;
    logic        push, pop;

    jkem_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_active (s_axis_tuser),
        .in_joy    (s_axis_tdata),
        .q_stat    (q_stat),
        .q_push    (push),
        .q_item    (push_item)
    );

    jkem_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    jkem_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_stat.valid),
        .q_item      (head_item),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_code    (m_axis_tdata),
        .out_pressed (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

endmodule
